// ----- sv/sac_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sac_pkg
// types and codes shared by the sorted alarm queue core, its cells and checker
// ----------------------------------------------------------------------------
package sac_pkg;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    localparam logic [2:0] KIND_ADDED     = 3'd0;
    localparam logic [2:0] KIND_PAST      = 3'd1;
    localparam logic [2:0] KIND_FULL      = 3'd2;
    localparam logic [2:0] KIND_REMOVED   = 3'd3;
    localparam logic [2:0] KIND_NOT_FOUND = 3'd4;
    localparam logic [2:0] KIND_FIRED     = 3'd5;

    localparam logic [1:0] CELL_HOLD   = 2'd0;
    localparam logic [1:0] CELL_INSERT = 2'd1;
    localparam logic [1:0] CELL_DELETE = 2'd2;
    localparam logic [1:0] CELL_POP    = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] trigger_time;
        logic [3:0]  alarm_handle;
    } sac_cmd_t;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic        fired_valid;
        logic [3:0]  result_handle;
        logic [31:0] result_time;
        logic        last_result;
    } sac_result_t;

    typedef struct packed {
        logic [1:0] op;
        logic [3:0] handle;
    } sac_cell_ctl_t;

endpackage
`default_nettype wire

// ----- sv/sac_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sac_cell
// one slot of the sorted chain: holds a trigger time and handle; on insert it
// takes the new entry or the left neighbor's, on delete the right neighbor
// ----------------------------------------------------------------------------
module sac_cell
    import sac_pkg::*;
#(
    parameter int TIME_BITS = 32
)
(
    input  wire logic                 clk,
    input  wire sac_cell_ctl_t        ctl,
    input  wire logic [TIME_BITS-1:0] key,
    input  wire logic                 occupied,
    input  wire logic [TIME_BITS-1:0] left_trig,
    input  wire logic [3:0]           left_handle,
    input  wire logic                 left_stay,
    input  wire logic [TIME_BITS-1:0] right_trig,
    input  wire logic [3:0]           right_handle,
    input  wire logic                 taken_in,
    input  wire logic [TIME_BITS-1:0] sel_in,
    output logic [TIME_BITS-1:0]      trig,
    output logic [3:0]                handle,
    output logic                      stay,
    output logic                      taken_out,
    output logic [TIME_BITS-1:0]      sel_out
);

    logic [TIME_BITS-1:0] trig_reg;
    logic [TIME_BITS-1:0] trig_next;
    logic [3:0]           handle_reg;
    logic [3:0]           handle_next;
    logic                 match;

    assign match     = occupied && (handle_reg == ctl.handle);
    assign stay      = occupied && (trig_reg < key);
    assign taken_out = taken_in || match;
    assign sel_out   = sel_in | (match ? trig_reg : '0);
    assign trig      = trig_reg;
    assign handle    = handle_reg;

    always_comb
    begin
        trig_next   = trig_reg;
        handle_next = handle_reg;
        unique case (ctl.op)
            CELL_INSERT:
            begin
                if (!stay)
                begin
                    if (left_stay)
                    begin
                        trig_next   = key;
                        handle_next = ctl.handle;
                    end
                    else
                    begin
                        trig_next   = left_trig;
                        handle_next = left_handle;
                    end
                end
            end
            CELL_DELETE, CELL_POP:
            begin
                if (taken_out)
                begin
                    trig_next   = right_trig;
                    handle_next = right_handle;
                end
            end
            default:
            begin
                trig_next   = trig_reg;
                handle_next = handle_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        trig_reg   <= trig_next;
        handle_reg <= handle_next;
    end

endmodule
`default_nettype wire

// ----- sv/sorted_alarm_queue_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_alarm_queue_core
// timer queue kept sorted in a chain of cells, with handle map and current time
// ----------------------------------------------------------------------------
// add and remove: one result beat, registered from the EXEC state that start
//   enters; the next start is taken in that beat's cycle
// tick: n due alarms give n beats on consecutive cycles (one idle beat if none),
//   the first registered from EXEC; the chain shifts one entry per cycle
// results cannot be stalled; reset clears count, handle map and time at once
module sorted_alarm_queue_core
    import sac_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int TIME_BITS   = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire sac_cmd_t    command,
    output logic             busy,
    output logic             result_valid,
    output sac_result_t      result
);

    localparam int CAP = (QUEUE_DEPTH < 16) ? QUEUE_DEPTH : 16;
    localparam int IW  = $clog2(CAP);
    localparam int CW  = $clog2(CAP + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;

    logic [1:0]           state_reg;
    logic [1:0]           state_next;
    sac_cmd_t             cmd_reg;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic [CAP-1:0]       in_use_reg;
    logic [CAP-1:0]       in_use_next;
    logic [TIME_BITS-1:0] now_reg;
    logic [TIME_BITS-1:0] now_next;
    sac_result_t          result_reg;
    sac_result_t          result_next;
    logic                 result_valid_reg;
    logic                 result_valid_next;

    sac_cell_ctl_t        cell_ctl;
    logic [TIME_BITS-1:0] key;
    logic [TIME_BITS-1:0] t_in;
    logic [TIME_BITS-1:0] now_inc;
    logic [TIME_BITS-1:0] eval_now;
    logic [IW-1:0]        free_handle;
    logic                 handle_hit;
    logic                 due0;
    logic                 due1;

    logic [TIME_BITS-1:0] trig_w  [CAP];
    logic [3:0]           hnd_w   [CAP];
    logic                 stay_w  [CAP];
    logic                 taken_w [CAP];
    logic [TIME_BITS-1:0] sel_w   [CAP];
    logic [CAP-1:0]       occupied;

    assign t_in     = TIME_BITS'(cmd_reg.trigger_time);
    assign now_inc  = (&now_reg) ? now_reg : now_reg + 1'b1;
    assign eval_now = (state_reg == S_EXEC) ? now_inc : now_reg;
    assign key      = t_in;
    assign due0     = occupied[0] && (trig_w[0] <= eval_now);
    assign due1     = occupied[1] && (trig_w[1] <= eval_now);
    assign handle_hit = (5'(cmd_reg.alarm_handle) < 5'(CAP))
                        && in_use_reg[cmd_reg.alarm_handle[IW-1:0]];

    always_comb
    begin
        free_handle = '0;
        for (int i = CAP - 1; i >= 0; i--)
        begin
            if (!in_use_reg[i])
            begin
                free_handle = IW'(i);
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < CAP; g++)
        begin : g_cell
            logic [TIME_BITS-1:0] left_trig;
            logic [3:0]           left_handle;
            logic                 left_stay;
            logic [TIME_BITS-1:0] right_trig;
            logic [3:0]           right_handle;
            logic                 taken_in;
            logic [TIME_BITS-1:0] sel_in;

            assign occupied[g] = CW'(g) < count_reg;

            if (g == 0)
            begin : g_head
                assign left_trig   = key;
                assign left_handle = cell_ctl.handle;
                assign left_stay   = 1'b1;
                assign taken_in    = (cell_ctl.op == CELL_POP);
                assign sel_in      = '0;
            end
            else
            begin : g_body
                assign left_trig   = trig_w[g-1];
                assign left_handle = hnd_w[g-1];
                assign left_stay   = stay_w[g-1];
                assign taken_in    = taken_w[g-1];
                assign sel_in      = sel_w[g-1];
            end

            if (g == CAP - 1)
            begin : g_tail
                assign right_trig   = key;
                assign right_handle = cell_ctl.handle;
            end
            else
            begin : g_inner
                assign right_trig   = trig_w[g+1];
                assign right_handle = hnd_w[g+1];
            end

            sac_cell #(
                .TIME_BITS (TIME_BITS)
            ) u_cell (
                .clk          (clk),
                .ctl          (cell_ctl),
                .key          (key),
                .occupied     (occupied[g]),
                .left_trig    (left_trig),
                .left_handle  (left_handle),
                .left_stay    (left_stay),
                .right_trig   (right_trig),
                .right_handle (right_handle),
                .taken_in     (taken_in),
                .sel_in       (sel_in),
                .trig         (trig_w[g]),
                .handle       (hnd_w[g]),
                .stay         (stay_w[g]),
                .taken_out    (taken_w[g]),
                .sel_out      (sel_w[g])
            );
        end
    endgenerate

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        in_use_next       = in_use_reg;
        now_next          = now_reg;
        result_next       = result_reg;
        result_valid_next = 1'b0;
        cell_ctl.op       = CELL_HOLD;
        cell_ctl.handle   = cmd_reg.alarm_handle;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC, S_DRAIN:
            begin
                state_next = S_IDLE;
                if (state_reg == S_EXEC && cmd_reg.opcode == OP_ADD)
                begin
                    result_valid_next         = 1'b1;
                    result_next.fired_valid   = 1'b0;
                    result_next.result_time   = 32'(t_in);
                    result_next.last_result   = 1'b1;
                    result_next.result_handle = 4'd0;
                    if (t_in < now_reg)
                    begin
                        result_next.result_kind = KIND_PAST;
                    end
                    else if (count_reg == CW'(CAP))
                    begin
                        result_next.result_kind = KIND_FULL;
                    end
                    else
                    begin
                        result_next.result_kind   = KIND_ADDED;
                        result_next.result_handle = 4'(free_handle);
                        cell_ctl.op               = CELL_INSERT;
                        cell_ctl.handle           = 4'(free_handle);
                        count_next                = count_reg + 1'b1;
                        in_use_next[free_handle]  = 1'b1;
                    end
                end
                else if (state_reg == S_EXEC && cmd_reg.opcode == OP_REMOVE)
                begin
                    result_valid_next         = 1'b1;
                    result_next.fired_valid   = 1'b0;
                    result_next.last_result   = 1'b1;
                    result_next.result_handle = cmd_reg.alarm_handle;
                    if (handle_hit)
                    begin
                        result_next.result_kind = KIND_REMOVED;
                        result_next.result_time = 32'(sel_w[CAP-1]);
                        cell_ctl.op             = CELL_DELETE;
                        count_next              = count_reg - 1'b1;
                        in_use_next[cmd_reg.alarm_handle[IW-1:0]] = 1'b0;
                    end
                    else
                    begin
                        result_next.result_kind = KIND_NOT_FOUND;
                        result_next.result_time = 32'd0;
                    end
                end
                else if (cmd_reg.opcode == OP_TICK)
                begin
                    if (state_reg == S_EXEC)
                    begin
                        now_next = now_inc;
                    end
                    result_next.result_kind = KIND_FIRED;
                    if (due0)
                    begin
                        result_valid_next         = 1'b1;
                        result_next.fired_valid   = 1'b1;
                        result_next.result_handle = hnd_w[0];
                        result_next.result_time   = 32'(trig_w[0]);
                        result_next.last_result   = !due1;
                        cell_ctl.op               = CELL_POP;
                        count_next                = count_reg - 1'b1;
                        in_use_next[hnd_w[0][IW-1:0]] = 1'b0;
                        if (due1)
                        begin
                            state_next = S_DRAIN;
                        end
                    end
                    else if (state_reg == S_EXEC)
                    begin
                        result_valid_next         = 1'b1;
                        result_next.fired_valid   = 1'b0;
                        result_next.result_handle = 4'd0;
                        result_next.result_time   = 32'd0;
                        result_next.last_result   = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            in_use_reg       <= '0;
            now_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            in_use_reg       <= in_use_next;
            now_reg          <= now_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (state_reg == S_IDLE && start)
        begin
            cmd_reg <= command;
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
`default_nettype wire

// ----- sv/sac_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sac_checker
// port-level checks of the sorted alarm queue core, bound to the top level
// ----------------------------------------------------------------------------
module sac_checker
    import sac_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        result_valid,
    input wire sac_result_t result
);

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && !start) |=> !result_valid)
        else $error("result beat without a command");

    a_more_keeps_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last_result) |-> busy)
        else $error("non-last beat while idle");

    a_single_beat_kinds: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.result_kind != KIND_FIRED) |-> result.last_result)
        else $error("add or remove result not marked last");

    a_fired_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.fired_valid) |-> result.result_kind == KIND_FIRED)
        else $error("fired beat with wrong kind");

endmodule

bind sorted_alarm_queue_core sac_checker u_sac_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);
`default_nettype wire

// ----- test/tb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// self-checking bench for sorted_alarm_queue_core: a behavioral copy of the
// alarm queue predicts every result beat of each accepted command, and the
// beats the core emits are compared in order; directed cases cover idle ticks,
// equal-time ordering, unknown handles, past and full rejects and a 15-alarm
// drain, then a random mix of fill bursts, drains and noise runs to the end
// ----------------------------------------------------------------------------
module tb;
    import sac_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int ALARM_CAPACITY  = 16;
    localparam int STALL_LIMIT     = 1000;
    localparam int DRAIN_LIMIT     = 200;
    localparam int RANDOM_COMMANDS = 330;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    sac_cmd_t    command = '0;
    logic        busy;
    logic        result_valid;
    sac_result_t result;

    sorted_alarm_queue_core #(
        .QUEUE_DEPTH (16),
        .TIME_BITS   (32)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .command      (command),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predicted queue contents
    logic [31:0] alarm_trig [ALARM_CAPACITY];
    logic [3:0]  alarm_hnd [ALARM_CAPACITY];
    int          alarm_count = 0;
    logic [15:0] handles_taken = '0;
    logic [31:0] alarm_now = '0;

    sac_result_t pending_results [$];
    sac_result_t expected_beat;

    int err_count = 0;
    int beat_count = 0;
    int idle_cycles = 0;
    int idle_max = 11;
    int add_count = 0;
    int remove_count = 0;
    int tick_count = 0;
    int fired_count = 0;
    int full_count = 0;
    int past_count = 0;
    int random_sent = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (err_count < 40)
            $display("mismatch %s: got %0h expected %0h (beat %0d)",
                     what, got, want, beat_count);
        err_count++;
    endtask

    function automatic sac_result_t make_result(input logic [2:0] kind, input logic fired,
                                                input logic [3:0] hnd, input logic [31:0] t,
                                                input logic last);
        sac_result_t r;
        r.result_kind   = kind;
        r.fired_valid   = fired;
        r.result_handle = hnd;
        r.result_time   = t;
        r.last_result   = last;
        return r;
    endfunction

    task automatic drop_alarm_at(input int pos);
        int i;
        handles_taken[alarm_hnd[pos]] = 1'b0;
        for (i = pos; i + 1 < alarm_count; i++)
        begin
            alarm_trig[i] = alarm_trig[i + 1];
            alarm_hnd[i]  = alarm_hnd[i + 1];
        end
        alarm_count--;
    endtask

    task automatic predict_alarm_results(input sac_cmd_t cmd);
        logic [31:0] t;
        int          h;
        int          pos;
        int          i;
        int          n;
        bit          found;
        sac_result_t r;
        case (cmd.opcode)
            OP_ADD:
            begin
                t = cmd.trigger_time;
                if (t < alarm_now)
                begin
                    pending_results.push_back(make_result(KIND_PAST, 1'b0, 4'd0, t, 1'b1));
                    past_count++;
                end
                else if (alarm_count >= ALARM_CAPACITY)
                begin
                    pending_results.push_back(make_result(KIND_FULL, 1'b0, 4'd0, t, 1'b1));
                    full_count++;
                end
                else
                begin
                    h = 0;
                    while (h < 16 && handles_taken[h])
                        h++;
                    pos = 0;
                    while (pos < alarm_count && alarm_trig[pos] < t)
                        pos++;
                    for (i = alarm_count; i > pos; i--)
                    begin
                        alarm_trig[i] = alarm_trig[i - 1];
                        alarm_hnd[i]  = alarm_hnd[i - 1];
                    end
                    alarm_trig[pos] = t;
                    alarm_hnd[pos]  = h[3:0];
                    alarm_count++;
                    handles_taken[h] = 1'b1;
                    pending_results.push_back(make_result(KIND_ADDED, 1'b0, h[3:0], t, 1'b1));
                end
            end
            OP_REMOVE:
            begin
                found = 1'b0;
                if (handles_taken[cmd.alarm_handle])
                begin
                    for (pos = 0; pos < alarm_count && !found; pos++)
                    begin
                        if (alarm_hnd[pos] == cmd.alarm_handle)
                        begin
                            t = alarm_trig[pos];
                            drop_alarm_at(pos);
                            pending_results.push_back(make_result(KIND_REMOVED, 1'b0,
                                                      cmd.alarm_handle, t, 1'b1));
                            found = 1'b1;
                        end
                    end
                end
                if (!found)
                    pending_results.push_back(make_result(KIND_NOT_FOUND, 1'b0,
                                              cmd.alarm_handle, 32'd0, 1'b1));
            end
            OP_TICK:
            begin
                if (alarm_now != '1)
                    alarm_now++;
                n = 0;
                while (alarm_count > 0 && alarm_trig[0] <= alarm_now && n < 16)
                begin
                    pending_results.push_back(make_result(KIND_FIRED, 1'b1, alarm_hnd[0],
                                              alarm_trig[0], 1'b0));
                    drop_alarm_at(0);
                    n++;
                end
                fired_count += n;
                if (n == 0)
                    pending_results.push_back(make_result(KIND_FIRED, 1'b0, 4'd0, 32'd0, 1'b1));
                else
                begin
                    r = pending_results.pop_back();
                    r.last_result = 1'b1;
                    pending_results.push_back(r);
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic send_alarm_cmd(input logic [1:0] op, input logic [31:0] trig,
                                  input logic [3:0] hnd);
        sac_cmd_t cmd;
        int       gap;
        cmd.opcode       = op;
        cmd.trigger_time = trig;
        cmd.alarm_handle = hnd;
        gap = $urandom_range(0, idle_max);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        command <= cmd;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_alarm_results(cmd);
        case (op)
            OP_ADD:    add_count++;
            OP_REMOVE: remove_count++;
            OP_TICK:   tick_count++;
            default:
            begin
            end
        endcase
    endtask

    task automatic compare_beat(input sac_result_t got, input sac_result_t want);
        if (got.result_kind !== want.result_kind)
            report_mismatch("result_kind", 32'(got.result_kind), 32'(want.result_kind));
        if (got.fired_valid !== want.fired_valid)
            report_mismatch("fired_valid", 32'(got.fired_valid), 32'(want.fired_valid));
        if (got.result_handle !== want.result_handle)
            report_mismatch("result_handle", 32'(got.result_handle),
                            32'(want.result_handle));
        if (got.result_time !== want.result_time)
            report_mismatch("result_time", got.result_time, want.result_time);
        if (got.last_result !== want.last_result)
            report_mismatch("last_result", 32'(got.last_result), 32'(want.last_result));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (pending_results.size() == 0)
                report_mismatch("beat with nothing pending", 32'(result.result_kind), 32'd0);
            else
            begin
                expected_beat = pending_results.pop_front();
                compare_beat(result, expected_beat);
            end
            beat_count++;
        end
    end

    // watchdog on cycles with neither a command nor a result beat
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || result_valid)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("timeout after %0d quiet cycles", idle_cycles);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    function automatic logic [3:0] pick_taken_handle();
        logic [3:0] h;
        int         tries;
        h = 4'($urandom);
        for (tries = 0; tries < 64 && !handles_taken[h]; tries++)
            h = 4'($urandom);
        return h;
    endfunction

    task automatic apply_reset();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
    endtask

    task automatic test_idle_tick();
        send_alarm_cmd(OP_TICK, $urandom, 4'($urandom));
    endtask

    task automatic test_add_remove();
        send_alarm_cmd(OP_ADD, 32'd0, 4'hf);
        send_alarm_cmd(OP_ADD, 32'd0, 4'h0);
        send_alarm_cmd(OP_ADD, 32'hffff_ffff, 4'h5);
        send_alarm_cmd(OP_REMOVE, 32'hffff_ffff, 4'd15);
        send_alarm_cmd(OP_REMOVE, 32'd0, 4'd1);
        send_alarm_cmd(OP_REMOVE, 32'd0, 4'd1);
    endtask

    task automatic test_past_reject();
        send_alarm_cmd(OP_TICK, 32'd0, 4'd0);
        send_alarm_cmd(OP_ADD, 32'd0, 4'd0);
    endtask

    task automatic test_full_queue();
        int i;
        for (i = 0; i < ALARM_CAPACITY - 1; i++)
            send_alarm_cmd(OP_ADD, alarm_now + 32'd1, 4'($urandom));
        send_alarm_cmd(OP_ADD, alarm_now + 32'd2, 4'd0);
        send_alarm_cmd(OP_ADD, 32'd0, 4'd0);
        send_alarm_cmd(OP_TICK, 32'd0, 4'd0);
    endtask

    task automatic test_unused_opcode();
        send_alarm_cmd(OP_UNUSED, $urandom, 4'($urandom));
        send_alarm_cmd(OP_TICK, 32'd0, 4'd0);
    endtask

    task automatic send_random_add();
        int          sel;
        logic [31:0] t;
        sel = $urandom_range(0, 9);
        if (sel <= 6)
            t = alarm_now + $urandom_range(0, 12);
        else if (sel == 7)
            t = alarm_now;
        else if (sel == 8 && alarm_now > 0)
            t = alarm_now - $urandom_range(1, alarm_now);
        else
            t = $urandom;
        send_alarm_cmd(OP_ADD, t, 4'($urandom));
    endtask

    task automatic test_random_mix();
        int seg;
        int i;
        int sel;
        int len;
        while (random_sent < RANDOM_COMMANDS)
        begin
            idle_max = ($urandom_range(0, 3) == 0) ? 0 : 11;
            seg = $urandom_range(0, 5);
            if (seg == 0)
            begin
                // fill burst of adds that may run past capacity
                len = $urandom_range(10, 18);
                for (i = 0; i < len; i++)
                begin
                    send_alarm_cmd(OP_ADD, alarm_now + $urandom_range(0, 6), 4'($urandom));
                    random_sent++;
                end
            end
            else if (seg == 1)
            begin
                len = $urandom_range(3, 8);
                for (i = 0; i < len; i++)
                begin
                    send_alarm_cmd(OP_TICK, $urandom, 4'($urandom));
                    random_sent++;
                end
            end
            else
            begin
                for (i = 0; i < 20; i++)
                begin
                    sel = $urandom_range(0, 99);
                    if (sel < 40)
                    begin
                        send_random_add();
                        random_sent++;
                    end
                    else if (sel < 65)
                    begin
                        if ($urandom_range(0, 4) != 0)
                            send_alarm_cmd(OP_REMOVE, $urandom, pick_taken_handle());
                        else
                            send_alarm_cmd(OP_REMOVE, $urandom, 4'($urandom));
                        random_sent++;
                    end
                    else if (sel < 97)
                    begin
                        send_alarm_cmd(OP_TICK, $urandom, 4'($urandom));
                        random_sent++;
                    end
                    else
                        send_alarm_cmd(OP_UNUSED, $urandom, 4'($urandom));
                end
            end
        end
    endtask

    initial
    begin
        int drain_wait;
        apply_reset();
        test_idle_tick();
        test_add_remove();
        test_past_reject();
        test_full_queue();
        test_unused_opcode();
        test_random_mix();
        start <= 1'b0;
        drain_wait = 0;
        while (pending_results.size() != 0 && drain_wait < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_wait++;
        end
        repeat (20) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch("beats never arrived", 32'(pending_results.size()), 32'd0);
        $display("run: %0d adds, %0d removes, %0d ticks; %0d result beats checked",
                 add_count, remove_count, tick_count, beat_count);
        $display("run: %0d alarms fired, %0d full rejects, %0d past rejects, end time %0d",
                 fired_count, full_count, past_count, alarm_now);
        if (err_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
`default_nettype wire
